// ===== rtl/local_alignment_affine_gap_scorer_core_defines.svh =====
// Assertion macros shared by the local alignment scorer RTL.
// No dependencies; included by the top level only.
`ifndef LOCAL_ALIGNMENT_AFFINE_GAP_SCORER_CORE_DEFINES_SVH
`define LOCAL_ALIGNMENT_AFFINE_GAP_SCORER_CORE_DEFINES_SVH

`define LAGSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define LAGSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lagsc_pkg.sv =====
// Types and constants of the local alignment scorer.
// No dependencies; used by the interfaces, the cell and the top level.
package lagsc_pkg;

	localparam int SYM_W   = 5;
	localparam int TSC_W   = 8;
	localparam int GAP_W   = 9;
	localparam int SCORE_W = 15;
	localparam int PPOS_W  = 13;
	localparam int SPOS_W  = 7;
	localparam int EXT_W   = 8;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TABLE  = 2'd2,
		CMD_SCORE  = 2'd3
	} cmd_t;

	localparam logic REG_GAP_OPEN   = 1'b0;
	localparam logic REG_GAP_EXTEND = 1'b1;

	typedef struct packed {
		logic                     clr;
		logic [EXT_W-1:0]         app_sym;
		logic signed [GAP_W-1:0]  gap_open;
		logic signed [GAP_W-1:0]  gap_extend;
		logic signed [TSC_W-1:0]  tscore;
	} lagsc_ctl_t;

endpackage

// ===== rtl/lagsc_ifs.sv =====
// Handshake channel interfaces for command items and result items.
// Depends on lagsc_pkg.
interface lagsc_cmd_if import lagsc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              cmd;
	logic [SYM_W-1:0]        symbol;
	logic [SYM_W-1:0]        column_symbol;
	logic signed [TSC_W-1:0] table_score;
	modport source (output valid, cmd, symbol, column_symbol, table_score, input ready);
	modport sink (input valid, cmd, symbol, column_symbol, table_score, output ready);
endinterface

interface lagsc_res_if import lagsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               best_found;
	logic [SCORE_W-1:0] best_score;
	logic [PPOS_W-1:0]  best_pattern_pos;
	logic [SPOS_W-1:0]  best_subject_pos;
	logic [PPOS_W-1:0]  column_index;
	modport source (output valid, best_found, best_score, best_pattern_pos,
		best_subject_pos, column_index, input ready);
	modport sink (input valid, best_found, best_score, best_pattern_pos,
		best_subject_pos, column_index, output ready);
endinterface

// ===== rtl/lagsc_cell.sv =====
// One subject position of the scoring row: holds its symbol and its DP row state.
// Depends on lagsc_pkg.
module lagsc_cell import lagsc_pkg::*; #(
	parameter int SB    = 16,
	parameter int AB    = 5,
	parameter int POS_W = 7,
	parameter int POS   = 1,
	parameter bit FIRST = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lagsc_ctl_t            ctl,
	input  logic                  app_en,
	input  logic                  req,
	input  logic                  act,
	input  logic signed [SB-1:0]  diag_i,
	input  logic signed [SB-1:0]  left_i,
	input  logic signed [SB-1:0]  across_i,
	output logic signed [SB-1:0]  diag_o,
	output logic signed [SB-1:0]  left_o,
	output logic signed [SB-1:0]  across_o,
	output logic [AB-1:0]         sym_o,
	output logic signed [SB-1:0]  c_o,
	output logic [POS_W-1:0]      pos_o
);

	localparam int SW = SB + 2;
	localparam logic signed [SW-1:0] WHI = {3'b000, {(SB-1){1'b1}}};
	localparam logic signed [SW-1:0] WLO = {3'b111, {(SB-1){1'b0}}};
	localparam logic signed [SB-1:0] LO  = {1'b1, {(SB-1){1'b0}}};

	function automatic logic signed [SB-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [SB-1:0] r;
		if (v > WHI) r = WHI[SB-1:0];
		else if (v < WLO) r = LO;
		else r = v[SB-1:0];
		return r;
	endfunction

	function automatic logic signed [SW-1:0] ext(input logic signed [SB-1:0] v);
		return {{2{v[SB-1]}}, v};
	endfunction

	logic signed [SB-1:0] prev_q, gap_q, diag_q, left_q, across_q;
	logic [AB-1:0]        sym_q;
	logic signed [SB-1:0] c1, open, extn, pg, c2, o2, e2, acr, c3, cz;
	logic signed [SW-1:0] go_w, ge_w, ts_w;

	always_comb begin
		go_w = {{(SW-GAP_W){ctl.gap_open[GAP_W-1]}}, ctl.gap_open};
		ge_w = {{(SW-GAP_W){ctl.gap_extend[GAP_W-1]}}, ctl.gap_extend};
		ts_w = {{(SW-TSC_W){ctl.tscore[TSC_W-1]}}, ctl.tscore};
		c1   = sat(ext(diag_i) + ts_w);
		open = sat(ext(prev_q) + go_w + ge_w);
		extn = sat(ext(gap_q) + ge_w);
		pg   = (open >= extn) ? open : extn;
		c2   = (c1 < pg) ? pg : c1;
		o2   = sat(ext(left_i) + go_w + ge_w);
		e2   = sat(ext(across_i) + ge_w);
		acr  = (o2 >= e2) ? o2 : e2;
		c3   = (!FIRST && (c2 < acr)) ? acr : c2;
		cz   = (c3 <= 0) ? '0 : c3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			gap_q  <= LO;
		end else if (ctl.clr) begin
			prev_q <= '0;
			gap_q  <= LO;
		end else if (act) begin
			prev_q <= cz;
			gap_q  <= pg;
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			diag_q   <= prev_q;
			left_q   <= cz;
			across_q <= FIRST ? LO : acr;
		end
		if (app_en) begin
			sym_q <= ctl.app_sym[AB-1:0];
		end
	end

	assign diag_o   = diag_q;
	assign left_o   = left_q;
	assign across_o = across_q;
	assign sym_o    = req ? sym_q : '0;
	assign c_o      = act ? cz : '0;
	assign pos_o    = act ? POS_W'(POS) : '0;

endmodule

// ===== rtl/local_alignment_affine_gap_scorer_core.sv =====
// Top level of the local alignment scorer: command decode, table, row of cells, best tracking.
// Depends on lagsc_pkg, lagsc_ifs, lagsc_cell and the defines header.
//
//   channel   dir   carries
//   cmd_ch    in    cmd, symbol, column_symbol, table_score
//   res_ch    out   best_found, best_score, best_pattern_pos, best_subject_pos, column_index
//   cfg_*     in    gap_open (index 0), gap_extend (index 1)
//
// Clear, append and table items do not leave the idle state. For a pattern item the scoring
// token walks the row one cell a cycle, behind the single registered read port of the table.
// Reset is asynchronous and needs no clearing pass; the subject and table stores are
// not reset. A stalled result is held while the next item may be accepted; a following
// pattern item then waits in its last cycle until the held result is taken.
`include "local_alignment_affine_gap_scorer_core_defines.svh"
module local_alignment_affine_gap_scorer_core import lagsc_pkg::*; #(
	parameter int SUBJECT_MAX   = 64,
	parameter int PATTERN_MAX   = 4096,
	parameter int ALPHABET_BITS = 5,
	parameter int SCORE_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	lagsc_cmd_if.sink         cmd_ch,
	lagsc_res_if.source       res_ch,
	input  logic              cfg_wen,
	input  logic              cfg_index,
	input  logic [GAP_W-1:0]  cfg_data
);

	localparam int SB  = SCORE_BITS;
	localparam int AB  = ALPHABET_BITS;
	localparam int LW  = $clog2(SUBJECT_MAX + 1);
	localparam int PCW = $clog2(PATTERN_MAX + 1);
	localparam int TD  = 1 << (2 * AB);
	localparam logic signed [SB-1:0] LO = {1'b1, {(SB-1){1'b0}}};

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

	state_t                  state_q;
	logic [SUBJECT_MAX-1:0]  req_q, act_q, app_en;
	logic [AB-1:0]           sym_q;
	logic [LW-1:0]           length_q;
	logic [PCW-1:0]          pcount_q, best_row_q;
	logic [LW-1:0]           best_col_q;
	logic signed [SB-1:0]    best_value_q;
	logic                    best_valid_q;
	logic signed [GAP_W-1:0] go_q, ge_q;
	logic signed [TSC_W-1:0] table_q [TD];
	logic signed [TSC_W-1:0] tdata_q;
	logic                    out_v_q;
	logic                    out_found_q;
	logic [SCORE_W-1:0]      out_score_q;
	logic [PPOS_W-1:0]       out_ppos_q, out_cidx_q;
	logic [SPOS_W-1:0]       out_spos_q;

	logic                    accept;
	logic [EXT_W-1:0]        sym_ext, col_ext;
	lagsc_ctl_t              ctl;
	logic [AB-1:0]           subj_sym;
	logic signed [SB-1:0]    act_c;
	logic [LW-1:0]           act_pos;
	logic                    any_act;
	logic [32:0]             best_w;
	logic [31:0]             row_w, col_w, cnt_w;

	logic signed [SB-1:0] diag_w [SUBJECT_MAX];
	logic signed [SB-1:0] left_w [SUBJECT_MAX];
	logic signed [SB-1:0] acr_w  [SUBJECT_MAX];
	logic [AB-1:0]        sym_w  [SUBJECT_MAX];
	logic signed [SB-1:0] c_w    [SUBJECT_MAX];
	logic [LW-1:0]        pos_w  [SUBJECT_MAX];

	assign accept  = cmd_ch.valid && cmd_ch.ready;
	assign cmd_ch.ready = (state_q == S_IDLE);
	assign sym_ext = {{(EXT_W-SYM_W){1'b0}}, cmd_ch.symbol};
	assign col_ext = {{(EXT_W-SYM_W){1'b0}}, cmd_ch.column_symbol};

	always_comb begin
		ctl.clr        = accept && (cmd_ch.cmd == CMD_CLEAR);
		ctl.app_sym    = sym_ext;
		ctl.gap_open   = go_q;
		ctl.gap_extend = ge_q;
		ctl.tscore     = tdata_q;
	end

	always_comb begin
		subj_sym = '0;
		act_c    = '0;
		act_pos  = '0;
		for (int j = 0; j < SUBJECT_MAX; j++) begin
			app_en[j] = accept && (cmd_ch.cmd == CMD_APPEND) && (length_q == LW'(j));
			subj_sym  = subj_sym | sym_w[j];
			act_c     = act_c | c_w[j];
			act_pos   = act_pos | pos_w[j];
		end
		any_act = |act_q;
	end

	for (genvar j = 0; j < SUBJECT_MAX; j++) begin : g_cell
		if (j == 0) begin : g_first
			lagsc_cell #(.SB(SB), .AB(AB), .POS_W(LW), .POS(j + 1), .FIRST(1'b1)) u_cell (
				.clk, .arst_n, .ctl,
				.app_en(app_en[j]), .req(req_q[j]), .act(act_q[j]),
				.diag_i('0), .left_i('0), .across_i(LO),
				.diag_o(diag_w[j]), .left_o(left_w[j]), .across_o(acr_w[j]),
				.sym_o(sym_w[j]), .c_o(c_w[j]), .pos_o(pos_w[j])
			);
		end else begin : g_next
			lagsc_cell #(.SB(SB), .AB(AB), .POS_W(LW), .POS(j + 1), .FIRST(1'b0)) u_cell (
				.clk, .arst_n, .ctl,
				.app_en(app_en[j]), .req(req_q[j]), .act(act_q[j]),
				.diag_i(diag_w[j-1]), .left_i(left_w[j-1]), .across_i(acr_w[j-1]),
				.diag_o(diag_w[j]), .left_o(left_w[j]), .across_o(acr_w[j]),
				.sym_o(sym_w[j]), .c_o(c_w[j]), .pos_o(pos_w[j])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd_ch.cmd == CMD_TABLE)) begin
			table_q[{sym_ext[AB-1:0], col_ext[AB-1:0]}] <= cmd_ch.table_score;
		end
		tdata_q <= table_q[{sym_q, subj_sym}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= -9'sd10;
			ge_q <= -9'sd1;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_GAP_OPEN:   go_q <= cfg_data;
				REG_GAP_EXTEND: ge_q <= cfg_data;
				default:        go_q <= go_q;
			endcase
		end
	end

	always_comb begin
		best_w = 33'($unsigned(best_value_q));
		row_w  = 32'(best_row_q);
		col_w  = 32'(best_col_q);
		cnt_w  = 32'(pcount_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= '0;
			act_q        <= '0;
			sym_q        <= '0;
			length_q     <= '0;
			pcount_q     <= '0;
			best_value_q <= '0;
			best_valid_q <= 1'b0;
			best_row_q   <= '0;
			best_col_q   <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready && (state_q != S_DONE)) out_v_q <= 1'b0;
			if (any_act && (!best_valid_q || act_c > best_value_q)) begin
				best_valid_q <= 1'b1;
				best_value_q <= act_c;
				best_row_q   <= pcount_q;
				best_col_q   <= act_pos;
			end
			act_q <= req_q;
			for (int j = 0; j < SUBJECT_MAX - 1; j++) begin
				req_q[j+1] <= req_q[j] && (LW'(j + 1) < length_q);
			end
			req_q[0] <= accept && (cmd_ch.cmd == CMD_SCORE) && (length_q != '0);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd_ch.cmd)
							CMD_CLEAR: begin
								length_q     <= '0;
								pcount_q     <= '0;
								best_value_q <= '0;
								best_valid_q <= 1'b0;
								best_row_q   <= '0;
								best_col_q   <= '0;
							end
							CMD_APPEND: begin
								if (length_q < LW'(SUBJECT_MAX)) length_q <= length_q + 1'b1;
							end
							CMD_TABLE: begin
								state_q <= S_IDLE;
							end
							CMD_SCORE: begin
								sym_q    <= sym_ext[AB-1:0];
								if (pcount_q < PCW'(PATTERN_MAX)) pcount_q <= pcount_q + 1'b1;
								state_q  <= S_RUN;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RUN: begin
					if ((req_q == '0) && (act_q == '0)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_v_q || res_ch.ready) begin
						out_v_q     <= 1'b1;
						out_found_q <= best_valid_q;
						out_score_q <= (best_w > 33'd32767) ? 15'h7fff : best_w[SCORE_W-1:0];
						out_ppos_q  <= row_w[PPOS_W-1:0];
						out_spos_q  <= col_w[SPOS_W-1:0];
						out_cidx_q  <= cnt_w[PPOS_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_ch.valid            = out_v_q;
	assign res_ch.best_found       = out_found_q;
	assign res_ch.best_score       = out_score_q;
	assign res_ch.best_pattern_pos = out_ppos_q;
	assign res_ch.best_subject_pos = out_spos_q;
	assign res_ch.column_index     = out_cidx_q;

	`LAGSC_ASSERT_NOW(a_token_single, 1'b1, $onehot0(req_q) && $onehot0(act_q), "more than one cell active")
	`LAGSC_ASSERT_NOW(a_busy_no_ready, (act_q != '0) || (req_q != '0), !cmd_ch.ready, "item taken while row busy")
	`LAGSC_ASSERT_NEXT(a_act_follows_req, req_q != '0, act_q != '0, "table read not followed by cell update")

endmodule
